// ----- design/mbrr_pkg.sv -----
// Package with the shared constants and types of the Modbus TCP register responder.
`timescale 1ns / 1ps

package mbrr_pkg;

    // Holding register store geometry.
    localparam int REG_COUNT = 64;
    localparam int REG_AW    = $clog2(REG_COUNT);

    // Largest register count that one read may ask for.
    localparam int MAX_READ  = 16;

    // Byte positions within a response frame.
    localparam int HDR_BYTES = 9;
    localparam int MAX_LAST  = HDR_BYTES - 1 + 2 * MAX_READ;
    localparam int IDX_W     = $clog2(MAX_LAST + 1);

    // Supported function codes.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

    // Length field of a write echo, and the fixed part of a read length.
    localparam logic [15:0] WRITE_LEN     = 16'd6;
    localparam logic [15:0] READ_LEN_BASE = 16'd3;

    typedef logic [15:0] word_t;
    typedef logic [7:0]  byte_t;

endpackage

// ----- design/modbus_tcp_register_responder_top.sv -----
// Modbus TCP holding register responder: request sequencer, register store and byte output.
// Order: an accepted request moves the sequencer to ST_EMIT, and each response byte is then
// loaded into the output register. Rate: one response byte per cycle while out_ready is high;
// a dropped request leaves the sequencer idle. The byte sequencer and its index counter set
// the pace; in_ready is low while a frame is emitted, so no new request is taken mid-frame.
// Reset: asynchronous, active low; the store reads as zero after reset through per-entry
// valid flags, so no clearing pass is needed.
`timescale 1ns / 1ps

module modbus_tcp_register_responder_top
    import mbrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] transaction_id,
    input  logic [15:0] protocol_id,
    input  logic [7:0]  unit_id,
    input  logic [7:0]  cmd,
    input  logic [15:0] first_addr,
    input  logic [15:0] count_or_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  resp_byte,
    output logic        last
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Control and output registers.
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    final_idx_reg, final_idx_next;
    logic                is_read_reg, is_read_next;
    logic [REG_AW-1:0]   rd_addr_reg, rd_addr_next;
    logic                out_valid_reg, out_valid_next;
    byte_t               resp_byte_reg, resp_byte_next;
    logic                last_reg, last_next;
    logic [REG_COUNT-1:0] vld_reg;

    // Payload registers for the request in flight.
    word_t tid_reg, pid_reg, addr_reg, arg_reg;
    byte_t unit_reg, lo_hold_reg;

    // Store and its registered read port.
    word_t mem [REG_COUNT];
    word_t mem_q_reg;
    logic  mem_vq_reg;
    word_t rd_word;

    logic  accept;
    logic  read_ok;
    logic  write_ok;
    logic  load_out;
    byte_t sel_byte;
    word_t len_word;
    logic [16:0] end_addr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign resp_byte = resp_byte_reg;
    assign last      = last_reg;

    // Request checks against the store bounds and the read limit.
    assign end_addr = {1'b0, first_addr} + {1'b0, count_or_value};
    assign read_ok  = (cmd == FC_READ_HOLDING) && (count_or_value != 16'd0)
                   && (count_or_value <= 16'(MAX_READ))
                   && (end_addr <= 17'(REG_COUNT));
    assign write_ok = (cmd == FC_WRITE_SINGLE)
                   && ({1'b0, first_addr} < 17'(REG_COUNT));

    // Entries never written read as zero.
    assign rd_word  = mem_vq_reg ? mem_q_reg : 16'd0;
    assign len_word = is_read_reg ? (READ_LEN_BASE + {arg_reg[14:0], 1'b0}) : WRITE_LEN;

    // The output register takes a new word when it is empty or being drained.
    assign load_out = !out_valid_reg || out_ready;

    // Byte selection for the current frame position.
    always_comb
    begin
        sel_byte = 8'd0;
        if (is_read_reg && (idx_reg >= IDX_W'(HDR_BYTES)))
        begin
            // Odd positions past the header carry the high byte of the next register.
            sel_byte = idx_reg[0] ? rd_word[15:8] : lo_hold_reg;
        end
        else
        begin
            case (idx_reg)
                IDX_W'(0):  sel_byte = tid_reg[15:8];
                IDX_W'(1):  sel_byte = tid_reg[7:0];
                IDX_W'(2):  sel_byte = pid_reg[15:8];
                IDX_W'(3):  sel_byte = pid_reg[7:0];
                IDX_W'(4):  sel_byte = len_word[15:8];
                IDX_W'(5):  sel_byte = len_word[7:0];
                IDX_W'(6):  sel_byte = unit_reg;
                IDX_W'(7):  sel_byte = is_read_reg ? FC_READ_HOLDING : FC_WRITE_SINGLE;
                IDX_W'(8):  sel_byte = is_read_reg ? {arg_reg[6:0], 1'b0} : addr_reg[15:8];
                IDX_W'(9):  sel_byte = addr_reg[7:0];
                IDX_W'(10): sel_byte = arg_reg[15:8];
                IDX_W'(11): sel_byte = arg_reg[7:0];
                default:    sel_byte = 8'd0;
            endcase
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        final_idx_next = final_idx_reg;
        is_read_next   = is_read_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg;
        resp_byte_next = resp_byte_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (read_ok || write_ok))
                begin
                    state_next   = ST_EMIT;
                    idx_next     = '0;
                    is_read_next = read_ok;
                    rd_addr_next = first_addr[REG_AW-1:0];
                    if (read_ok)
                    begin
                        final_idx_next = IDX_W'(HDR_BYTES - 1)
                                       + {count_or_value[IDX_W-2:0], 1'b0};
                    end
                    else
                    begin
                        final_idx_next = IDX_W'(HDR_BYTES + 2);
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    resp_byte_next = sel_byte;
                    last_next      = (idx_reg == final_idx_reg);
                    idx_next       = idx_reg + IDX_W'(1);
                    // Step the read port once the high byte of a register has left.
                    if (is_read_reg && (idx_reg >= IDX_W'(HDR_BYTES)) && idx_reg[0])
                    begin
                        rd_addr_next = rd_addr_reg + REG_AW'(1);
                    end
                    if (idx_reg == final_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            final_idx_reg <= '0;
            is_read_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
            resp_byte_reg <= 8'd0;
            last_reg      <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            final_idx_reg <= final_idx_next;
            is_read_reg   <= is_read_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
            resp_byte_reg <= resp_byte_next;
            last_reg      <= last_next;
            if (accept && write_ok)
            begin
                vld_reg[first_addr[REG_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tid_reg  <= transaction_id;
            pid_reg  <= protocol_id;
            unit_reg <= unit_id;
            addr_reg <= first_addr;
            arg_reg  <= count_or_value;
        end
        // Keep the low byte while the high byte goes out, since the read port moves on.
        if ((state_reg == ST_EMIT) && load_out && is_read_reg
            && (idx_reg >= IDX_W'(HDR_BYTES)) && idx_reg[0])
        begin
            lo_hold_reg <= rd_word[7:0];
        end
    end

    // Holding register store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept && write_ok)
        begin
            mem[first_addr[REG_AW-1:0]] <= count_or_value;
        end
        mem_q_reg  <= mem[rd_addr_reg];
        mem_vq_reg <= vld_reg[rd_addr_reg];
    end

endmodule

// ----- bench/tb_modbus_tcp_register_responder_top.sv -----
// Self-checking testbench for the Modbus TCP holding register responder.
`timescale 1ns / 1ps

module tb_modbus_tcp_register_responder_top;
    import mbrr_pkg::*;

    // Function codes that the responder must ignore.
    localparam byte_t FC_NONE           = 8'h00;
    localparam byte_t FC_READ_COILS     = 8'h01;
    localparam byte_t FC_READ_INPUT     = 8'h04;
    localparam byte_t FC_WRITE_COIL     = 8'h05;
    localparam byte_t FC_WRITE_MULTIPLE = 8'h10;
    localparam byte_t FC_ALL_ONES       = 8'hFF;

    // Marks a table column that is left to the register model.
    localparam int NONE = -1;

    localparam int RANDOM_ITEMS  = 225;
    localparam int HOLD_AT       = 60;
    localparam int PAUSE_AT      = 130;
    localparam int CALM_AT       = 190;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        word_t tid;
        word_t pid;
        byte_t unit;
        byte_t cmd;
        word_t addr;
        word_t arg;
    } mb_request_t;

    typedef struct {
        mb_request_t req;
        int          frame_len;
        int          fill_word;
    } stim_row_t;

    typedef struct {
        byte_t value;
        logic  is_last;
    } expected_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [7:0]  unit_id;
    logic [7:0]  cmd;
    logic [15:0] first_addr;
    logic [15:0] count_or_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  resp_byte;
    logic        last;

    word_t          holding_regs [REG_COUNT];
    expected_byte_t pending_bytes [$];
    int             error_count = 0;
    bit             calm = 0;
    bit             hold_req = 0;

    modbus_tcp_register_responder_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .transaction_id (transaction_id),
        .protocol_id    (protocol_id),
        .unit_id        (unit_id),
        .cmd            (cmd),
        .first_addr     (first_addr),
        .count_or_value (count_or_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .resp_byte      (resp_byte),
        .last           (last)
    );

    // Directed requests: reset contents, field extremes, every dropped case, then echoes.
    stim_row_t dir_table [0:24] = '{
        '{'{16'h0000, 16'h0000, 8'h00, FC_READ_HOLDING,   16'd0,     16'd1},    11, 0},
        '{'{16'hFFFF, 16'hFFFF, 8'hFF, FC_READ_HOLDING,   16'd0,     16'd16},   41, 0},
        '{'{16'h1234, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd48,    16'd16},   41, 0},
        '{'{16'h0001, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd0,     16'd0},    0,  NONE},
        '{'{16'h0002, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd0,     16'd17},   0,  NONE},
        '{'{16'h0003, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd0,     16'hFFFF}, 0,  NONE},
        '{'{16'h0004, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd49,    16'd16},   0,  NONE},
        '{'{16'h0005, 16'h0000, 8'h01, FC_READ_HOLDING,   16'hFFFF,  16'd1},    0,  NONE},
        '{'{16'h0006, 16'h0000, 8'h01, FC_WRITE_SINGLE,   16'd64,    16'h1234}, 0,  NONE},
        '{'{16'h0007, 16'h0000, 8'h01, FC_WRITE_SINGLE,   16'hFFFF,  16'hFFFF}, 0,  NONE},
        '{'{16'h0008, 16'h0000, 8'h01, FC_NONE,           16'd0,     16'd1},    0,  NONE},
        '{'{16'h0009, 16'h0000, 8'h01, FC_ALL_ONES,       16'd0,     16'd1},    0,  NONE},
        '{'{16'h000A, 16'h0000, 8'h01, FC_READ_INPUT,     16'd0,     16'd1},    0,  NONE},
        '{'{16'h000B, 16'h0000, 8'h01, FC_WRITE_COIL,     16'd0,     16'hFF00}, 0,  NONE},
        '{'{16'h000C, 16'h0000, 8'h01, FC_WRITE_MULTIPLE, 16'd2,     16'h0001}, 0,  NONE},
        '{'{16'hFFFF, 16'hFFFF, 8'hFF, FC_WRITE_SINGLE,   16'd0,     16'hFFFF}, 12, NONE},
        '{'{16'h0000, 16'h0000, 8'h00, FC_WRITE_SINGLE,   16'd63,    16'h0000}, 12, NONE},
        '{'{16'h5AA5, 16'h0001, 8'h11, FC_WRITE_SINGLE,   16'd63,    16'hA55A}, 12, NONE},
        '{'{16'h0010, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd0,     16'd1},    11, 16'hFFFF},
        '{'{16'h0011, 16'h0000, 8'h01, FC_READ_HOLDING,   16'd63,    16'd1},    11, 16'hA55A},
        '{'{16'h0012, 16'h0000, 8'h02, FC_WRITE_SINGLE,   16'd1,     16'h8001}, NONE, NONE},
        '{'{16'h0013, 16'h0000, 8'h02, FC_WRITE_SINGLE,   16'd62,    16'h7FFE}, NONE, NONE},
        '{'{16'h0014, 16'h0000, 8'h02, FC_READ_HOLDING,   16'd0,     16'd2},    NONE, NONE},
        '{'{16'h0015, 16'h0000, 8'h02, FC_READ_HOLDING,   16'd48,    16'd16},   NONE, NONE},
        '{'{16'h8000, 16'h0001, 8'h80, FC_READ_HOLDING,   16'd1,     16'd1},    NONE, NONE}
    };

    // Clock and a single reset at the start.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Register model: builds the response frame of one request and applies any write.
    function automatic void answer_request(input mb_request_t r, output byte_t frame [$]);
        word_t len;
        word_t w;
        frame = {};
        if (r.cmd == FC_READ_HOLDING) begin
            if (r.arg == 16'd0 || int'(r.arg) > MAX_READ) return;
            if (int'(r.addr) + int'(r.arg) > REG_COUNT) return;
            len = READ_LEN_BASE + 16'(2 * r.arg);
            frame = {r.tid[15:8], r.tid[7:0], r.pid[15:8], r.pid[7:0],
                     len[15:8], len[7:0], r.unit, FC_READ_HOLDING, byte_t'(2 * r.arg)};
            for (int i = 0; i < int'(r.arg); i++) begin
                w = holding_regs[int'(r.addr) + i];
                frame.push_back(w[15:8]);
                frame.push_back(w[7:0]);
            end
        end
        else if (r.cmd == FC_WRITE_SINGLE) begin
            if (int'(r.addr) >= REG_COUNT) return;
            holding_regs[int'(r.addr)] = r.arg;
            frame = {r.tid[15:8], r.tid[7:0], r.pid[15:8], r.pid[7:0],
                     WRITE_LEN[15:8], WRITE_LEN[7:0], r.unit, FC_WRITE_SINGLE,
                     r.addr[15:8], r.addr[7:0], r.arg[15:8], r.arg[7:0]};
        end
    endfunction

    // Random request: mostly well-formed reads and writes, the rest dropped requests.
    function automatic mb_request_t random_request();
        mb_request_t r;
        int          pick;
        int          n;
        r.tid  = word_t'($urandom);
        r.pid  = word_t'($urandom);
        r.unit = byte_t'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 40) begin
            r.cmd  = FC_WRITE_SINGLE;
            r.addr = word_t'($urandom_range(0, REG_COUNT - 1));
            r.arg  = word_t'($urandom);
        end
        else if (pick < 80) begin
            n      = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                : $urandom_range(1, MAX_READ);
            r.cmd  = FC_READ_HOLDING;
            r.arg  = word_t'(n);
            r.addr = word_t'($urandom_range(0, REG_COUNT - n));
        end
        else if (pick < 86) begin
            // Any function code other than the two supported ones.
            do r.cmd = byte_t'($urandom);
            while (r.cmd == FC_READ_HOLDING || r.cmd == FC_WRITE_SINGLE);
            r.addr = word_t'($urandom);
            r.arg  = word_t'($urandom);
        end
        else if (pick < 91) begin
            // Read count of zero or above the limit.
            r.cmd  = FC_READ_HOLDING;
            r.addr = word_t'($urandom_range(0, REG_COUNT - 1));
            r.arg  = ($urandom_range(0, 1) == 0) ? 16'd0
                                                 : word_t'($urandom_range(MAX_READ + 1, 16'hFFFF));
        end
        else if (pick < 96) begin
            // Read range that runs past the end of the store.
            n      = $urandom_range(1, MAX_READ);
            r.cmd  = FC_READ_HOLDING;
            r.arg  = word_t'(n);
            r.addr = word_t'($urandom_range(REG_COUNT - n + 1, 16'hFFFF));
        end
        else begin
            // Write beyond the store.
            r.cmd  = FC_WRITE_SINGLE;
            r.addr = word_t'($urandom_range(REG_COUNT, 16'hFFFF));
            r.arg  = word_t'($urandom);
        end
        return r;
    endfunction

    // Offers one request, waits for the handshake and queues the predicted frame.
    task automatic send_request(input mb_request_t r, output byte_t frame [$]);
        expected_byte_t e;
        @(negedge clk);
        in_valid       <= 1'b1;
        transaction_id <= r.tid;
        protocol_id    <= r.pid;
        unit_id        <= r.unit;
        cmd            <= r.cmd;
        first_addr     <= r.addr;
        count_or_value <= r.arg;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        answer_request(r, frame);
        foreach (frame[i]) begin
            e.value   = frame[i];
            e.is_last = (i == frame.size() - 1);
            pending_bytes.push_back(e);
        end
    endtask

    // Drops valid for an idle burst whose length is given by n.
    task automatic idle_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Stops offering and waits until every queued response word has come out.
    task automatic drain_responses();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
    endtask

    // Response side: random stall bursts, and one long hold on request.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Response checker: each word against the oldest expectation.
    always @(posedge clk) begin
        expected_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected response word: expected none, actual byte %02h last %0b",
                         $time, resp_byte, last);
                error_count++;
            end
            else begin
                want = pending_bytes.pop_front();
                if (resp_byte !== want.value) begin
                    $display("%0t: resp_byte mismatch: expected %02h, actual %02h",
                             $time, want.value, resp_byte);
                    error_count++;
                end
                if (last !== want.is_last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.is_last, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk) begin
        int quiet;
        if (!rst_n) begin
            quiet = 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet = 0;
        end
        else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: timeout with %0d response words outstanding",
                         $time, pending_bytes.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        byte_t       frame [$];
        mb_request_t req;
        word_t       got;
        int          items_sent;

        in_valid       = 1'b0;
        transaction_id = '0;
        protocol_id    = '0;
        unit_id        = '0;
        cmd            = '0;
        first_addr     = '0;
        count_or_value = '0;
        foreach (holding_regs[i]) holding_regs[i] = '0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed table; fixed columns also cross-check the register model.
        foreach (dir_table[k]) begin
            send_request(dir_table[k].req, frame);
            if (dir_table[k].frame_len != NONE && frame.size() != dir_table[k].frame_len) begin
                $display("%0t: row %0d frame length: expected %0d, actual %0d",
                         $time, k, dir_table[k].frame_len, frame.size());
                error_count++;
            end
            if (dir_table[k].fill_word != NONE) begin
                for (int i = HDR_BYTES; i + 1 < frame.size(); i += 2) begin
                    got = {frame[i], frame[i + 1]};
                    if (got != word_t'(dir_table[k].fill_word)) begin
                        $display("%0t: row %0d register data: expected %04h, actual %04h",
                                 $time, k, word_t'(dir_table[k].fill_word), got);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
        end
        drain_responses();

        // Random requests until enough have been sent.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent == HOLD_AT) hold_req = 1'b1;
            if (items_sent == PAUSE_AT) drain_responses();
            calm = (items_sent >= CALM_AT);
            req = random_request();
            send_request(req, frame);
            items_sent++;
            if (!calm && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
        end

        // Final drain, then a short settle for any stray output.
        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0) begin
            $display("%0t: %0d expected response words never arrived",
                     $time, pending_bytes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mbrr_pkg.sv
design/modbus_tcp_register_responder_top.sv
bench/tb_modbus_tcp_register_responder_top.sv
